// ===== rtl/core/sptq_pkg.sv =====
// ----------------------------------------------------------------------------
// sptq_pkg
// Shared types, widths and codes of the sorted periodic timer queue.
// ----------------------------------------------------------------------------
package sptq_pkg;

  localparam int DEFAULT_CAPACITY = 16;

  localparam int OP_W   = 2;
  localparam int ID_W   = 32;
  localparam int PER_W  = 32;
  localparam int TIME_W = 48;
  localparam int DL_W   = TIME_W + 1;
  localparam int CLR_W  = 5;

  localparam logic [TIME_W-1:0] DELAY_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_SET     = 2'd0,
    OP_DELETE  = 2'd1,
    OP_TRIGGER = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  // Command broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_FIND,
    CELL_MARK,
    CELL_REMOVE_HIT,
    CELL_REMOVE_HEAD,
    CELL_INSERT
  } cell_cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PER_W-1:0] period;
    logic [DL_W-1:0]  deadline;
  } entry_t;

  typedef struct packed {
    cell_cmd_t         cmd;
    entry_t            ins;
    logic [TIME_W-1:0] now;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_REMOVE,
    ST_INSERT,
    ST_MARK,
    ST_CHECK,
    ST_REARM,
    ST_SUMMARY
  } state_t;

  typedef struct packed {
    logic              fired;
    logic [ID_W-1:0]   fired_id;
    logic [TIME_W-1:0] next_delay;
    logic              queue_empty;
    logic              not_found;
    logic              table_full;
    logic [CLR_W-1:0]  cleared_count;
    logic              last;
  } result_t;

endpackage

// ===== rtl/core/sptq_in_if.sv =====
// ----------------------------------------------------------------------------
// sptq_in_if
// Request channel of the timer queue: valid/ready with the request fields.
// ----------------------------------------------------------------------------
interface sptq_in_if import sptq_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ID_W-1:0]   timer_id;
  logic [PER_W-1:0]  period;
  logic [TIME_W-1:0] now;

  modport source (output valid, output operation, output timer_id, output period,
                  output now, input ready);
  modport sink   (input valid, input operation, input timer_id, input period,
                  input now, output ready);

endinterface

// ===== rtl/core/sptq_out_if.sv =====
// ----------------------------------------------------------------------------
// sptq_out_if
// Result channel of the timer queue: valid/ready with the result fields.
// ----------------------------------------------------------------------------
interface sptq_out_if import sptq_pkg::*; ();

  logic              valid;
  logic              ready;
  logic              fired;
  logic [ID_W-1:0]   fired_id;
  logic [TIME_W-1:0] next_delay;
  logic              queue_empty;
  logic              not_found;
  logic              table_full;
  logic [CLR_W-1:0]  cleared_count;
  logic              last;

  modport source (output valid, output fired, output fired_id, output next_delay,
                  output queue_empty, output not_found, output table_full,
                  output cleared_count, output last, input ready);
  modport sink   (input valid, input fired, input fired_id, input next_delay,
                  input queue_empty, input not_found, input table_full,
                  input cleared_count, input last, output ready);

endinterface

// ===== rtl/core/sptq_cell.sv =====
// ----------------------------------------------------------------------------
// sptq_cell
// One slot of the sorted timer chain: holds an entry, compares it and shifts
// data to or from its neighbours on command.
// ----------------------------------------------------------------------------
module sptq_cell import sptq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  logic       occupied,
  input  entry_t     left_entry,
  input  logic       left_flag,
  input  logic       left_after,
  input  logic       left_hit,
  input  entry_t     right_entry,
  input  logic       right_flag,
  output entry_t     entry,
  output logic       flag,
  output logic       after,
  output logic       hit
);

  entry_t entry_r, entry_nxt;
  logic   flag_r, flag_nxt;
  logic   hit_r, hit_nxt;

  // New deadline belongs at or before this slot
  assign after = !occupied || (entry_r.deadline > ctrl.ins.deadline);
  // First matching slot and every slot behind it
  assign hit   = hit_r || left_hit;
  assign entry = entry_r;
  assign flag  = flag_r;

  always_comb begin
    entry_nxt = entry_r;
    flag_nxt  = flag_r;
    hit_nxt   = hit_r;
    case (ctrl.cmd)
      CELL_FIND: begin
        hit_nxt = occupied && (entry_r.id == ctrl.ins.id);
      end
      CELL_MARK: begin
        flag_nxt = occupied && (entry_r.deadline <= {1'b0, ctrl.now});
      end
      CELL_REMOVE_HIT: begin
        if (hit) begin
          entry_nxt = right_entry;
          flag_nxt  = right_flag;
        end
      end
      CELL_REMOVE_HEAD: begin
        entry_nxt = right_entry;
        flag_nxt  = right_flag;
      end
      CELL_INSERT: begin
        if (left_after) begin
          entry_nxt = left_entry;
          flag_nxt  = left_flag;
        end else if (after) begin
          entry_nxt = ctrl.ins;
          flag_nxt  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (!rst_n) begin
      flag_r <= 1'b0;
      hit_r  <= 1'b0;
    end else begin
      flag_r <= flag_nxt;
      hit_r  <= hit_nxt;
    end
  end

endmodule

// ===== rtl/core/sorted_periodic_timer_queue_core.sv =====
// ----------------------------------------------------------------------------
// sorted_periodic_timer_queue_core
// Deadline-ordered table of periodic timers built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_req  : one request per handshake (operation, timer_id, period, now).
//   out_res : one or more results per request; the final one has last = 1 and
//             carries the delay to the earliest deadline and the status flags.
//   Requests are handled one at a time; in_req.ready is high only while the
//   sequencer is idle.
//   Steps per request, from acceptance to the summary result being loaded
//   into the output register: set and delete search the chain and shift out
//   a matching entry; set then shifts its entry in sorted, unless a new id
//   meets a full table; clear empties the table at acceptance; trigger marks
//   the expired entries, then gives each fired timer one head removal and
//   one sorted re-insertion.
//   Reset clears the entry count and the sequencer; slot contents stay
//   undefined and are never read before being written.
//   A stalled receiver holds the output register; the sequencer waits on it
//   before loading the next result, so nothing is dropped.
// ----------------------------------------------------------------------------
module sorted_periodic_timer_queue_core import sptq_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input logic       clk,
  input logic       rst_n,
  sptq_in_if.sink   in_req,
  sptq_out_if.source out_res
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Sequencer and request holding registers
  state_t            state_r, state_nxt;
  op_t               req_op_r, req_op_nxt;
  logic [TIME_W-1:0] req_now_r, req_now_nxt;
  entry_t            ins_r, ins_nxt;
  logic              nf_r, nf_nxt;
  logic              full_r, full_nxt;
  logic [CNT_W-1:0]  cleared_r, cleared_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  // Output register
  logic    out_valid_r, out_valid_nxt;
  result_t out_r, out_nxt;

  // Chain signals
  cell_ctrl_t ctrl;
  entry_t     cell_entry [CAPACITY];
  logic       cell_flag  [CAPACITY];
  logic       cell_after [CAPACITY];
  logic       cell_hit   [CAPACITY];
  logic       cell_occ   [CAPACITY];

  logic              in_fire;
  logic              slot_ok;
  logic              found;
  logic              head_due;
  logic              is_full;
  logic [TIME_W+1:0] head_diff;
  logic [TIME_W-1:0] head_delay;
  op_t               in_op;

  assign in_op    = op_t'(in_req.operation);
  assign in_fire  = in_req.valid && in_req.ready;
  // Output register free now or being emptied this cycle
  assign slot_ok  = !out_valid_r || out_res.ready;
  // Search result ripples out of the last cell
  assign found    = cell_hit[CAPACITY-1];
  assign head_due = cell_occ[0] && cell_flag[0];
  assign is_full  = (count_r == CNT_W'(CAPACITY));

  // Delay to the head deadline, clamped at zero and saturated to 48 bits
  assign head_diff = {1'b0, cell_entry[0].deadline} - {2'b00, req_now_r};
  always_comb begin
    if (!cell_occ[0] || head_diff[TIME_W+1] || (head_diff == '0)) begin
      head_delay = '0;
    end else if (head_diff[TIME_W]) begin
      head_delay = DELAY_MAX;
    end else begin
      head_delay = head_diff[TIME_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Cell chain: entries kept sorted, occupied slots form a prefix
  // --------------------------------------------------------------------------
  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      entry_t l_entry, r_entry;
      logic   l_flag, l_after, l_hit, r_flag;

      assign cell_occ[gi] = (count_r > CNT_W'(gi));

      if (gi == 0) begin : g_head
        assign l_entry = '0;
        assign l_flag  = 1'b0;
        assign l_after = 1'b0;
        assign l_hit   = 1'b0;
      end else begin : g_body
        assign l_entry = cell_entry[gi-1];
        assign l_flag  = cell_flag[gi-1];
        assign l_after = cell_after[gi-1];
        assign l_hit   = cell_hit[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_tail
        assign r_entry = '0;
        assign r_flag  = 1'b0;
      end else begin : g_link
        assign r_entry = cell_entry[gi+1];
        assign r_flag  = cell_flag[gi+1];
      end

      sptq_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .occupied    (cell_occ[gi]),
        .left_entry  (l_entry),
        .left_flag   (l_flag),
        .left_after  (l_after),
        .left_hit    (l_hit),
        .right_entry (r_entry),
        .right_flag  (r_flag),
        .entry       (cell_entry[gi]),
        .flag        (cell_flag[gi]),
        .after       (cell_after[gi]),
        .hit         (cell_hit[gi])
      );
    end
  endgenerate

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_SET:     state_nxt = ST_FIND;
            OP_DELETE:  state_nxt = ST_FIND;
            OP_TRIGGER: state_nxt = ST_MARK;
            default:    state_nxt = ST_SUMMARY;
          endcase
        end
      end
      ST_FIND: state_nxt = ST_REMOVE;
      ST_REMOVE: begin
        // A present id frees its own slot, so only a new id can hit a full table
        if ((req_op_r == OP_SET) && (found || !is_full)) begin
          state_nxt = ST_INSERT;
        end else begin
          state_nxt = ST_SUMMARY;
        end
      end
      ST_INSERT: state_nxt = ST_SUMMARY;
      ST_MARK:   state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = head_due ? ST_REARM : ST_SUMMARY;
      ST_REARM: begin
        if (slot_ok) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_SUMMARY: begin
        if (slot_ok) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs, chain commands and register updates
  // --------------------------------------------------------------------------
  assign in_req.ready = (state_r == ST_IDLE);

  always_comb begin
    req_op_nxt    = req_op_r;
    req_now_nxt   = req_now_r;
    ins_nxt       = ins_r;
    nf_nxt        = nf_r;
    full_nxt      = full_r;
    cleared_nxt   = cleared_r;
    count_nxt     = count_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    ctrl.cmd      = CELL_HOLD;
    ctrl.ins      = ins_r;
    ctrl.now      = req_now_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          // Latch the request, precompute the set deadline and, on clear, empty the table
          req_op_nxt       = in_op;
          req_now_nxt      = in_req.now;
          ins_nxt.id       = in_req.timer_id;
          ins_nxt.period   = in_req.period;
          ins_nxt.deadline = {1'b0, in_req.now} + DL_W'(in_req.period);
          nf_nxt           = 1'b0;
          full_nxt         = 1'b0;
          cleared_nxt      = '0;
          if (in_op == OP_CLEAR) begin
            cleared_nxt = count_r;
            count_nxt   = '0;
          end
        end
      end
      ST_FIND: begin
        ctrl.cmd = CELL_FIND;
      end
      ST_REMOVE: begin
        if (found) begin
          ctrl.cmd  = CELL_REMOVE_HIT;
          count_nxt = count_r - CNT_W'(1);
        end
        if (req_op_r == OP_DELETE) begin
          nf_nxt = !found;
        end else begin
          full_nxt = !found && is_full;
        end
      end
      ST_INSERT: begin
        ctrl.cmd  = CELL_INSERT;
        count_nxt = count_r + CNT_W'(1);
      end
      ST_MARK: begin
        // Freeze the set of expired entries before any re-arming
        ctrl.cmd = CELL_MARK;
      end
      ST_CHECK: begin
        if (head_due) begin
          // Pop the head and hold it for re-insertion at now + period
          ctrl.cmd         = CELL_REMOVE_HEAD;
          count_nxt        = count_r - CNT_W'(1);
          ins_nxt.id       = cell_entry[0].id;
          ins_nxt.period   = cell_entry[0].period;
          ins_nxt.deadline = {1'b0, req_now_r} + DL_W'(cell_entry[0].period);
        end
      end
      ST_REARM: begin
        if (slot_ok) begin
          ctrl.cmd              = CELL_INSERT;
          count_nxt             = count_r + CNT_W'(1);
          out_valid_nxt         = 1'b1;
          out_nxt               = '0;
          out_nxt.fired         = 1'b1;
          out_nxt.fired_id      = ins_r.id;
        end
      end
      ST_SUMMARY: begin
        if (slot_ok) begin
          out_valid_nxt         = 1'b1;
          out_nxt               = '0;
          out_nxt.next_delay    = head_delay;
          out_nxt.queue_empty   = (count_r == '0);
          out_nxt.not_found     = nf_r;
          out_nxt.table_full    = full_r;
          out_nxt.cleared_count = CLR_W'(cleared_r);
          out_nxt.last          = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    req_op_r  <= req_op_nxt;
    req_now_r <= req_now_nxt;
    ins_r     <= ins_nxt;
    nf_r      <= nf_nxt;
    full_r    <= full_nxt;
    cleared_r <= cleared_nxt;
    out_r     <= out_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Drive the result channel
  assign out_res.valid         = out_valid_r;
  assign out_res.fired         = out_r.fired;
  assign out_res.fired_id      = out_r.fired_id;
  assign out_res.next_delay    = out_r.next_delay;
  assign out_res.queue_empty   = out_r.queue_empty;
  assign out_res.not_found     = out_r.not_found;
  assign out_res.table_full    = out_r.table_full;
  assign out_res.cleared_count = out_r.cleared_count;
  assign out_res.last          = out_r.last;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INSERT || (state_r == ST_REARM && slot_ok)) |-> !is_full)
    else $error("insertion into a full chain");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && count_r >= CNT_W'(2)) |->
      (cell_entry[0].deadline <= cell_entry[1].deadline))
    else $error("head entries out of deadline order");

  a_fired_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.fired) |->
      (!out_r.last && out_r.next_delay == '0 && !out_r.queue_empty))
    else $error("fired result carries summary fields");

  a_summary_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUMMARY && slot_ok) |=> (state_r == ST_IDLE && out_valid_r && out_r.last))
    else $error("summary result not issued on completion");

endmodule

// ===== tb/tb_sorted_periodic_timer_queue_core.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_periodic_timer_queue_core
// Self-checking bench for the timer queue: drives set, delete, trigger and
// clear requests over the request channel and matches every result against
// an in-bench deadline-ordered timer list.
// ----------------------------------------------------------------------------
module tb_sorted_periodic_timer_queue_core import sptq_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY       = DEFAULT_CAPACITY;
  // Worst request: trigger with every slot expired
  localparam int DRAIN_CYCLES   = 3 + 2 * CAPACITY + 32;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MIX_ITEMS      = 50;
  localparam int ID_POOL_SIZE   = 20;

  logic clk = 1'b0;
  logic rst_n;

  sptq_in_if  in_req ();
  sptq_out_if out_res ();

  sorted_periodic_timer_queue_core #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_res(out_res)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Bench-side copy of the timer table, earliest deadline at index 0
  entry_t  timer_list[$];
  // Results still owed by the block, oldest first
  result_t expected_results[$];

  int                send_idle_pct;
  int                recv_idle_pct;
  int                err_count;
  logic [TIME_W-1:0] clock_us;

  // --------------------------------------------------------------------------
  // Timer table prediction
  // --------------------------------------------------------------------------

  function automatic int find_timer(logic [ID_W-1:0] id);
    foreach (timer_list[i])
      if (timer_list[i].id == id) return i;
    return -1;
  endfunction

  // File an entry after every entry whose deadline is not later than its own
  function automatic void file_timer(logic [ID_W-1:0] id, logic [PER_W-1:0] per,
                                     logic [DL_W-1:0] deadline);
    entry_t ent;
    int     pos;
    ent.id       = id;
    ent.period   = per;
    ent.deadline = deadline;
    pos = 0;
    while (pos < timer_list.size() && timer_list[pos].deadline <= deadline) pos++;
    timer_list.insert(pos, ent);
  endfunction

  // Apply one request to the table and queue every result it owes
  function automatic void predict_timer_op(op_t op, logic [ID_W-1:0] id,
                                           logic [PER_W-1:0] per,
                                           logic [TIME_W-1:0] now_us);
    result_t          res;
    entry_t           expired[$];
    logic [DL_W-1:0]  now_dl;
    logic [DL_W-1:0]  gap;
    int               pos;
    logic             miss;
    logic             full;
    logic [CLR_W-1:0] cleared;
    now_dl  = {1'b0, now_us};
    miss    = 1'b0;
    full    = 1'b0;
    cleared = '0;
    case (op)
      OP_SET: begin
        pos = find_timer(id);
        // a known id is re-filed even when the table is full
        if (pos >= 0) begin
          timer_list.delete(pos);
          file_timer(id, per, now_dl + DL_W'(per));
        end else if (timer_list.size() >= CAPACITY) begin
          full = 1'b1;
        end else begin
          file_timer(id, per, now_dl + DL_W'(per));
        end
      end
      OP_DELETE: begin
        pos = find_timer(id);
        if (pos >= 0) timer_list.delete(pos);
        else miss = 1'b1;
      end
      OP_TRIGGER: begin
        // take all expired heads first, then re-arm them in the order taken,
        // so a zero-period timer fires only once per trigger
        while (timer_list.size() > 0 && timer_list[0].deadline <= now_dl)
          expired = {expired, timer_list.pop_front()};
        foreach (expired[i]) begin
          file_timer(expired[i].id, expired[i].period,
                     now_dl + DL_W'(expired[i].period));
          res              = '0;
          res.fired        = 1'b1;
          res.fired_id     = expired[i].id;
          expected_results = {expected_results, res};
        end
      end
      default: begin
        cleared = CLR_W'(timer_list.size());
        timer_list.delete();
      end
    endcase
    res               = '0;
    res.queue_empty   = (timer_list.size() == 0);
    res.not_found     = miss;
    res.table_full    = full;
    res.cleared_count = cleared;
    res.last          = 1'b1;
    if (timer_list.size() > 0 && timer_list[0].deadline > now_dl) begin
      gap = timer_list[0].deadline - now_dl;
      res.next_delay = (gap > {1'b0, DELAY_MAX}) ? DELAY_MAX : gap[TIME_W-1:0];
    end
    expected_results = {expected_results, res};
  endfunction

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------

  // Present one request, hold it until taken, then predict its results
  task automatic send_request(input op_t op, input logic [ID_W-1:0] id,
                              input logic [PER_W-1:0] per,
                              input logic [TIME_W-1:0] now_us);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid     <= 1'b1;
    in_req.operation <= op;
    in_req.timer_id  <= id;
    in_req.period    <= per;
    in_req.now       <= now_us;
    do @(posedge clk); while (!in_req.ready);
    predict_timer_op(op, id, per, now_us);
  endtask

  // --------------------------------------------------------------------------
  // Result receiver and checker
  // --------------------------------------------------------------------------

  // Drop ready at random to stall the result channel
  always @(posedge clk) begin
    out_res.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Compare each accepted result with the oldest outstanding one
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: fired=%0d fired_id=%0h last=%0d",
               out_res.fired, out_res.fired_id, out_res.last);
        err_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_res.fired !== want.fired) begin
          $error("fired: expected %0d, got %0d", want.fired, out_res.fired);
          err_count++;
        end
        if (out_res.fired_id !== want.fired_id) begin
          $error("fired_id: expected %0h, got %0h", want.fired_id, out_res.fired_id);
          err_count++;
        end
        if (out_res.next_delay !== want.next_delay) begin
          $error("next_delay: expected %0h, got %0h", want.next_delay, out_res.next_delay);
          err_count++;
        end
        if (out_res.queue_empty !== want.queue_empty) begin
          $error("queue_empty: expected %0d, got %0d", want.queue_empty,
                 out_res.queue_empty);
          err_count++;
        end
        if (out_res.not_found !== want.not_found) begin
          $error("not_found: expected %0d, got %0d", want.not_found, out_res.not_found);
          err_count++;
        end
        if (out_res.table_full !== want.table_full) begin
          $error("table_full: expected %0d, got %0d", want.table_full, out_res.table_full);
          err_count++;
        end
        if (out_res.cleared_count !== want.cleared_count) begin
          $error("cleared_count: expected %0d, got %0d", want.cleared_count,
                 out_res.cleared_count);
          err_count++;
        end
        if (out_res.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_res.last);
          err_count++;
        end
      end
    end
  end

  // End the run once neither channel has moved for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_req.valid && in_req.ready) || (out_res.valid && out_res.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Trigger, delete and clear on an empty table
  task automatic test_empty_table();
    send_request(OP_TRIGGER, '0, '0, '0);
    send_request(OP_DELETE, '0, '1, '1);
    send_request(OP_CLEAR, '1, '0, '0);
  endtask

  // Field extremes, zero period, equal deadlines and re-filing a known id
  task automatic test_ordering();
    send_request(OP_SET, '0, '0, '0);
    // deadline lands beyond 48 bits
    send_request(OP_SET, '1, '1, '1);
    // zero period: stays expired but fires once
    send_request(OP_TRIGGER, '1, '1, '0);
    send_request(OP_SET, 32'd5, 32'd100, '0);
    send_request(OP_SET, 32'd6, 32'd100, '0);
    // same deadline again: id 5 goes behind id 6
    send_request(OP_SET, 32'd5, 32'd100, '0);
    send_request(OP_TRIGGER, '0, '0, 48'd100);
    send_request(OP_DELETE, 32'd6, '0, 48'd100);
    send_request(OP_DELETE, 32'd7, '0, 48'd100);
    send_request(OP_CLEAR, '0, '0, 48'd100);
  endtask

  // Delay beyond 48 bits must saturate
  task automatic test_delay_saturation();
    send_request(OP_SET, 32'd9, '1, '1);
    send_request(OP_TRIGGER, '0, '0, '0);
    send_request(OP_CLEAR, '0, '0, '0);
  endtask

  // Fill the table, hit the full flag, re-file while full, then expire the lot
  task automatic test_full_table();
    logic [ID_W-1:0] filled_ids[CAPACITY];
    logic [63:0]     rnd;
    rnd      = {$urandom, $urandom};
    clock_us = {1'b0, rnd[TIME_W-2:0]};
    send_request(OP_CLEAR, $urandom, $urandom, clock_us);
    foreach (filled_ids[i]) begin
      filled_ids[i] = $urandom;
      clock_us      = clock_us + TIME_W'($urandom_range(0, 20));
      send_request(OP_SET, filled_ids[i], $urandom_range(1, 500), clock_us);
    end
    send_request(OP_SET, $urandom, $urandom_range(0, 500), clock_us);
    send_request(OP_SET, filled_ids[$urandom_range(0, CAPACITY - 1)], '0, clock_us);
    send_request(OP_DELETE, $urandom, $urandom, clock_us);
    clock_us = clock_us + TIME_W'(1000);
    send_request(OP_TRIGGER, $urandom, $urandom, clock_us);
  endtask

  // Mixed traffic over a small id pool, with a slice of unconstrained noise
  task automatic test_random_mix(input int count);
    logic [ID_W-1:0]  id_pool[ID_POOL_SIZE];
    logic [63:0]      rnd;
    logic [ID_W-1:0]  id;
    logic [PER_W-1:0] per;
    op_t              op;
    int               pick;
    foreach (id_pool[i]) id_pool[i] = $urandom;
    for (int n = 0; n < count; n++) begin
      rnd = {$urandom, $urandom};
      if ($urandom_range(0, 99) < 10) begin
        send_request(op_t'($urandom_range(0, 3)), $urandom, $urandom, rnd[TIME_W-1:0]);
      end else begin
        // advance the time mostly in small steps, with the odd jump
        if ($urandom_range(0, 99) < 5) clock_us = rnd[TIME_W-1:0];
        else clock_us = clock_us + TIME_W'($urandom_range(0, 60));
        pick = $urandom_range(0, 99);
        if (pick < 50)      op = OP_SET;
        else if (pick < 65) op = OP_DELETE;
        else if (pick < 95) op = OP_TRIGGER;
        else                op = OP_CLEAR;
        pick = $urandom_range(0, 99);
        if (pick < 80)      per = $urandom_range(0, 120);
        else if (pick < 90) per = '0;
        else                per = $urandom;
        id = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, ID_POOL_SIZE - 1)]
                                          : $urandom;
        send_request(op, id, per, clock_us);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    err_count        = 0;
    clock_us         = '0;
    send_idle_pct    = 7;
    recv_idle_pct    = 45;
    rst_n            <= 1'b0;
    in_req.valid     <= 1'b0;
    in_req.operation <= OP_SET;
    in_req.timer_id  <= '0;
    in_req.period    <= '0;
    in_req.now       <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender rarely idle, receiver stalls often
    test_empty_table();
    test_ordering();
    test_delay_saturation();
    test_full_table();
    test_random_mix(MIX_ITEMS);

    // sender idles often, receiver rarely stalls
    send_idle_pct = 45;
    recv_idle_pct = 7;
    test_full_table();
    test_random_mix(MIX_ITEMS);

    // back to back in both directions
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_full_table();
    test_random_mix(MIX_ITEMS);

    in_req.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    // let any stray result surface before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
